/* rtl/core/pwbd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwbd_pkg: shared types, constants and hash table
// Beat structs for both channels, the front-to-back work entry, register
// map and the 256-entry byte permutation.
// ----------------------------------------------------------------------------
package pwbd_pkg;

    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int CFG_ADDR_W      = 3;
    localparam int NUM_BUCKETS     = 32;
    localparam int HASH_START      = 5;

    localparam logic [7:0] MIN_LENGTH_RESET = 8'd50;

    // register index (paddr[2])
    localparam logic [0:0] REG_MIN_LENGTH = 1'b0;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_beat;

    typedef struct packed {
        logic        too_short;
        logic [7:0]  checksum_low;
        logic [7:0]  length_mid;
        logic [63:0] counts_low;
        logic [63:0] counts_high;
    } t_out_beat;

    // one classified byte, handed from front to back
    typedef struct packed {
        logic [23:0] window;
        logic        hash_en;
        logic        last;
        logic        too_short;
        logic [7:0]  checksum;
        logic [7:0]  length_mid;
    } t_work;

    localparam logic [7:0] PERM [256] = '{
        8'd98, 8'd6, 8'd85, 8'd150, 8'd36, 8'd23, 8'd112, 8'd164,
        8'd135, 8'd207, 8'd169, 8'd5, 8'd26, 8'd64, 8'd165, 8'd219,
        8'd61, 8'd20, 8'd68, 8'd89, 8'd130, 8'd63, 8'd52, 8'd102,
        8'd24, 8'd229, 8'd132, 8'd245, 8'd80, 8'd216, 8'd195, 8'd115,
        8'd90, 8'd168, 8'd156, 8'd203, 8'd177, 8'd120, 8'd2, 8'd190,
        8'd188, 8'd7, 8'd100, 8'd185, 8'd174, 8'd243, 8'd162, 8'd10,
        8'd237, 8'd18, 8'd253, 8'd225, 8'd8, 8'd208, 8'd172, 8'd244,
        8'd255, 8'd126, 8'd101, 8'd79, 8'd145, 8'd235, 8'd228, 8'd121,
        8'd123, 8'd251, 8'd67, 8'd250, 8'd161, 8'd0, 8'd107, 8'd97,
        8'd241, 8'd111, 8'd181, 8'd82, 8'd249, 8'd33, 8'd69, 8'd55,
        8'd59, 8'd153, 8'd29, 8'd9, 8'd213, 8'd167, 8'd84, 8'd93,
        8'd30, 8'd46, 8'd94, 8'd75, 8'd151, 8'd114, 8'd73, 8'd222,
        8'd197, 8'd96, 8'd210, 8'd45, 8'd16, 8'd227, 8'd248, 8'd202,
        8'd51, 8'd152, 8'd252, 8'd125, 8'd81, 8'd206, 8'd215, 8'd186,
        8'd39, 8'd158, 8'd178, 8'd187, 8'd131, 8'd136, 8'd1, 8'd49,
        8'd50, 8'd17, 8'd141, 8'd91, 8'd47, 8'd129, 8'd60, 8'd99,
        8'd154, 8'd35, 8'd86, 8'd171, 8'd105, 8'd34, 8'd38, 8'd200,
        8'd147, 8'd58, 8'd77, 8'd118, 8'd173, 8'd246, 8'd76, 8'd254,
        8'd133, 8'd232, 8'd196, 8'd144, 8'd198, 8'd124, 8'd53, 8'd4,
        8'd108, 8'd74, 8'd223, 8'd234, 8'd134, 8'd230, 8'd157, 8'd139,
        8'd189, 8'd205, 8'd199, 8'd128, 8'd176, 8'd19, 8'd211, 8'd236,
        8'd127, 8'd192, 8'd231, 8'd70, 8'd233, 8'd88, 8'd146, 8'd44,
        8'd183, 8'd201, 8'd22, 8'd83, 8'd13, 8'd214, 8'd116, 8'd109,
        8'd159, 8'd32, 8'd95, 8'd226, 8'd140, 8'd220, 8'd57, 8'd12,
        8'd221, 8'd31, 8'd209, 8'd182, 8'd143, 8'd92, 8'd149, 8'd184,
        8'd148, 8'd62, 8'd113, 8'd65, 8'd37, 8'd27, 8'd106, 8'd166,
        8'd3, 8'd14, 8'd204, 8'd72, 8'd21, 8'd41, 8'd56, 8'd66,
        8'd28, 8'd193, 8'd40, 8'd217, 8'd25, 8'd54, 8'd179, 8'd117,
        8'd238, 8'd87, 8'd240, 8'd155, 8'd180, 8'd170, 8'd242, 8'd212,
        8'd191, 8'd163, 8'd78, 8'd218, 8'd137, 8'd194, 8'd175, 8'd110,
        8'd43, 8'd119, 8'd224, 8'd71, 8'd122, 8'd142, 8'd42, 8'd160,
        8'd104, 8'd48, 8'd247, 8'd103, 8'd15, 8'd11, 8'd138, 8'd239
    };

    function automatic logic [7:0] perm_lookup(input logic [7:0] idx);
        return PERM[idx];
    endfunction

endpackage

/* rtl/core/pwbd_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwbd_front: byte intake and classification
// Keeps bit window, checksum and byte count; emits one work entry per beat.
// ----------------------------------------------------------------------------
module pwbd_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  pwbd_pkg::t_in_beat  i_in_beat,
    input  logic [7:0]          i_min_length,
    input  logic                i_full,
    output logic                o_push,
    output pwbd_pkg::t_work     o_work
);
    import pwbd_pkg::*;

    logic [23:0] r_window, n_window;
    logic [7:0]  r_sum,    n_sum;
    logic [31:0] r_count,  n_count;
    logic        accept;

    assign o_in_stall = i_full;
    assign accept     = i_in_valid && !i_full;

    always_comb begin
        n_window = {r_window[22:0], i_in_beat.data_byte[0]};
        // sum * 33 + byte, mod 256
        n_sum    = {r_sum[2:0], 5'b0} + r_sum + i_in_beat.data_byte;
        n_count  = r_count + 32'd1;
    end

    always_comb begin
        o_work.window     = n_window;
        o_work.hash_en    = (r_count >= 32'(HASH_START));
        o_work.last       = i_in_beat.last_byte;
        o_work.too_short  = (n_count < {24'b0, i_min_length});
        o_work.checksum   = n_sum;
        o_work.length_mid = n_count[15:8];
    end

    assign o_push = accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= '0;
            r_sum    <= '0;
            r_count  <= '0;
        end else if (accept) begin
            if (i_in_beat.last_byte) begin
                r_window <= '0;
                r_sum    <= '0;
                r_count  <= '0;
            end else begin
                r_window <= n_window;
                r_sum    <= n_sum;
                r_count  <= n_count;
            end
        end
    end

    // message state must be clear after a last beat
    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_in_beat.last_byte |=> r_count == 32'd0 && r_sum == 8'd0)
        else $error("front state not cleared after last beat");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_full |-> !o_push)
        else $error("push while queue full");

endmodule

/* rtl/core/pwbd_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwbd_queue: work queue between front and back
// Small show-ahead FIFO of work entries.
// ----------------------------------------------------------------------------
module pwbd_queue #(
    parameter int DEPTH = pwbd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  pwbd_pkg::t_work  i_work,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output pwbd_pkg::t_work  o_work
);
    import pwbd_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_work            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_work  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_work;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (do_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue count overflow");

    a_ptrs_match_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count == '0 |-> r_wr_ptr == r_rd_ptr)
        else $error("queue pointers disagree with count");

endmodule

/* rtl/core/pwbd_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwbd_back: hash chain, bucket counters and result register
// Three table rounds in three stages, then nibble increment and digest.
// ----------------------------------------------------------------------------
module pwbd_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  pwbd_pkg::t_work     i_work,
    output logic                o_pop,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output pwbd_pkg::t_out_beat o_out_beat
);
    import pwbd_pkg::*;

    logic                            r_s1_valid, r_s2_valid, r_s3_valid;
    t_work                           r_s1_work, r_s2_work, r_s3_work;
    logic [7:0]                      r_h1, r_h2, r_h3;
    logic [NUM_BUCKETS-1:0][3:0]     r_counts, n_counts;
    logic                            r_out_valid;
    t_out_beat                       r_out_beat;
    logic                            adv;
    logic                            hit;

    // whole pipe moves unless a finished result is held by the receiver
    assign adv   = !r_out_valid || !i_out_stall;
    assign o_pop = adv && i_valid;

    assign hit = r_s3_valid && r_s3_work.hash_en && (r_h3 < 8'(NUM_BUCKETS));

    always_comb begin
        for (int k = 0; k < NUM_BUCKETS; k++) begin
            n_counts[k] = r_counts[k] +
                          4'((hit && (r_h3[4:0] == 5'(k))) ? 1 : 0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_work <= i_work;
            r_h1      <= perm_lookup(i_work.window[7:0]);
            r_s2_work <= r_s1_work;
            r_h2      <= perm_lookup(r_h1 ^ r_s1_work.window[15:8]);
            r_s3_work <= r_s2_work;
            r_h3      <= perm_lookup(r_h2 ^ r_s2_work.window[23:16]);
            if (r_s3_valid && r_s3_work.last) begin
                if (r_s3_work.too_short) begin
                    r_out_beat <= '{too_short: 1'b1, default: '0};
                end else begin
                    r_out_beat.too_short    <= 1'b0;
                    r_out_beat.checksum_low <= r_s3_work.checksum;
                    r_out_beat.length_mid   <= r_s3_work.length_mid;
                    r_out_beat.counts_low   <= n_counts[15:0];
                    r_out_beat.counts_high  <= n_counts[31:16];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_counts    <= '0;
        end else if (adv) begin
            r_s1_valid  <= i_valid;
            r_s2_valid  <= r_s1_valid;
            r_s3_valid  <= r_s2_valid;
            r_out_valid <= r_s3_valid && r_s3_work.last;
            if (r_s3_valid && r_s3_work.last) begin
                r_counts <= '0;
            end else begin
                r_counts <= n_counts;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

    a_counts_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && r_s3_valid && r_s3_work.last |=> r_counts == '0)
        else $error("bucket counters not cleared after message");

    a_short_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_beat.too_short |->
            r_out_beat.checksum_low == 8'd0 && r_out_beat.length_mid == 8'd0 &&
            r_out_beat.counts_low == 64'd0 && r_out_beat.counts_high == 64'd0)
        else $error("short message result carries data");

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(r_out_valid && i_out_stall) |-> r_out_valid && $stable(r_out_beat))
        else $error("stalled result changed");

endmodule

/* rtl/core/window_pearson_bucket_digest.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// window_pearson_bucket_digest: byte-serial Pearson bucket digest
// Front classifies bytes, queue decouples, back hashes and counts buckets.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: one message byte per beat (i_in_valid / o_in_stall,
//   payload i_in_beat with data_byte and last_byte). Output channel: one
//   digest beat per message, issued after its last byte (o_out_valid /
//   i_out_stall, payload o_out_beat).
//   Throughput: one byte per cycle unless the receiver stalls, set by the
//   front state update and the three-stage table chain in the back, both
//   of which take a beat each cycle. A digest passes the queue write, three
//   hash stages and the result register before it shows on o_out_valid.
//   If the receiver stalls, the result register holds and the back pipe
//   freezes; the queue then fills and o_in_stall rises once it is full.
//   Reset clears window, checksum, byte count, bucket nibbles, the queue and
//   the pipe; min_length returns to 50. Each digest also clears message state.
//   min_length sits at APB byte address 0 and should only be written while
//   no message is in flight.
// ----------------------------------------------------------------------------
module window_pearson_bucket_digest #(
    parameter int QUEUE_DEPTH = pwbd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // byte input channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  pwbd_pkg::t_in_beat                  i_in_beat,
    // digest output channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output pwbd_pkg::t_out_beat                 o_out_beat,
    // APB configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [pwbd_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);
    import pwbd_pkg::*;

    logic [7:0] r_min_length;
    logic       cfg_wr;
    logic       full;
    logic       push;
    t_work      front_work;
    logic       q_valid;
    t_work      q_work;
    logic       pop;

    // ---- configuration ----
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite &&
                    (paddr[CFG_ADDR_W-1:2] == REG_MIN_LENGTH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_length <= MIN_LENGTH_RESET;
        end else if (cfg_wr) begin
            r_min_length <= pwdata[7:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[CFG_ADDR_W-1:2] == REG_MIN_LENGTH) begin
            prdata = {24'b0, r_min_length};
        end
    end

    // ---- front: intake and per-message state ----
    pwbd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in_beat    (i_in_beat),
        .i_min_length (r_min_length),
        .i_full       (full),
        .o_push       (push),
        .o_work       (front_work)
    );

    // ---- decoupling queue ----
    pwbd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_work  (front_work),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_work  (q_work)
    );

    // ---- back: hash chain, buckets, result ----
    pwbd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (q_valid),
        .i_work      (q_work),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_beat  (o_out_beat)
    );

endmodule
